FILE: rtl/ufcm_pkg.sv
`default_nettype none

package ufcm_pkg;

  localparam int FRAME_BYTES   = 7;
  localparam int PATTERN_COUNT = 9;

  localparam int ROW_BYTES  = 7;
  localparam int TABLE_ROWS = 9;

  // byte 2 of a frame carries the compare length
  localparam int LEN_POS = 2;

  localparam int PHASE_W     = $clog2(FRAME_BYTES);
  localparam int CMP_LIMIT   = (ROW_BYTES < FRAME_BYTES) ? ROW_BYTES : FRAME_BYTES;
  localparam int ACTIVE_ROWS = (PATTERN_COUNT < TABLE_ROWS) ? PATTERN_COUNT : TABLE_ROWS;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] code_t;
  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  localparam byte_t START_BYTE    = 8'hAA;
  localparam code_t NO_MATCH_CODE = 4'd9;

  localparam byte_t STATUS_ROWS [TABLE_ROWS][ROW_BYTES] = '{
    '{8'hAA, 8'h00, 8'h03, 8'h01, 8'h02, 8'h00, 8'hFA},
    '{8'hAA, 8'h00, 8'h03, 8'h01, 8'h01, 8'h00, 8'hFB},
    '{8'hAA, 8'h00, 8'h03, 8'h01, 8'h03, 8'h00, 8'hF9},
    '{8'hAA, 8'h00, 8'h03, 8'h01, 8'h06, 8'h00, 8'hF6},
    '{8'hAA, 8'h00, 8'h03, 8'h01, 8'h0B, 8'h00, 8'hF1},
    '{8'hAA, 8'h00, 8'h03, 8'h01, 8'h08, 8'h00, 8'hF4},
    '{8'hAA, 8'h00, 8'h03, 8'h01, 8'h0C, 8'h00, 8'hF0},
    '{8'hAA, 8'h00, 8'h02, 8'h00, 8'h02, 8'hFC, 8'hAA},
    '{8'hAA, 8'h00, 8'h03, 8'h0F, 8'h0F, 8'h00, 8'hDF}
  };

endpackage

`default_nettype wire

FILE: rtl/ufcm_in_if.sv
`default_nettype none

interface ufcm_in_if import ufcm_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/ufcm_out_if.sv
`default_nettype none

interface ufcm_out_if import ufcm_pkg::*;;
  logic  valid;
  logic  ready;
  code_t event_code;
  logic  matched;

  modport source (output valid, output event_code, output matched, input ready);
  modport sink   (input valid, input event_code, input matched, output ready);
endinterface

`default_nettype wire

FILE: rtl/uart_frame_command_matcher_core.sv
// Status frame matcher for a received serial byte stream.
//
// in_ch  : one received byte per transfer (valid/ready). A byte 0xAA opens a
//          frame while idle; other idle bytes are dropped. Inside a frame every
//          byte is kept until FRAME_BYTES bytes are in.
// out_ch : one transfer per completed frame: event_code is the index of the
//          first matching status row, or 9 with matched low if none matched.
//
// The last byte of a frame closes it into the collect stage; the result
// register loads it from there when the result register is empty or out_ch
// takes the old result.
// Throughput: one byte per cycle. in_ch.ready is high unless a finished frame
// sits in the collect stage while the result register is full and stalled.
// A stall on out_ch holds the result; at most one more frame can be completed
// behind it before in_ch.ready drops.
//
// Reset (rst_n low, synchronous) returns the collector to idle and empties both
// stages. The frame store itself is not cleared; it is always fully written
// before a frame is matched.
`default_nettype none

module uart_frame_command_matcher_core import ufcm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ufcm_in_if.sink    in_ch,
  ufcm_out_if.source out_ch
);

  logic   frame_valid;
  logic   frame_ready;
  frame_t frame;

  // frame assembly: phase counter plus byte store
  ufcm_collect u_collect (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  // pattern compare and result register
  ufcm_match u_match (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/ufcm_collect.sv
`default_nettype none

module ufcm_collect import ufcm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  ufcm_in_if.sink in_ch,
  output logic   frame_valid,
  input  logic   frame_ready,
  output frame_t frame
);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               frame_valid_r, frame_valid_nxt;
  frame_t             store_r;
  logic               take;
  logic               store_en;

  // a finished frame may be overwritten only when the matcher takes it now
  assign in_ch.ready = !frame_valid_r || frame_ready;
  assign take        = in_ch.valid && in_ch.ready;
  // idle bytes other than the start byte are dropped
  assign store_en    = take && ((phase_r != '0) || (in_ch.rx_byte == START_BYTE));

  always_comb begin
    phase_nxt       = phase_r;
    frame_valid_nxt = frame_valid_r && !frame_ready;
    if (store_en) begin
      if (phase_r == PHASE_W'(FRAME_BYTES - 1)) begin
        phase_nxt       = '0;
        frame_valid_nxt = 1'b1;
      end else begin
        phase_nxt = phase_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= '0;
      frame_valid_r <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      frame_valid_r <= frame_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      store_r[phase_r] <= in_ch.rx_byte;
    end
  end

  assign frame_valid = frame_valid_r;
  assign frame       = store_r;

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r < PHASE_W'(FRAME_BYTES))
    else $error("frame phase out of range");

  a_frame_held: assert property (@(posedge clk) disable iff (!rst_n)
    frame_valid_r && !frame_ready |=> frame_valid_r && $stable(store_r))
    else $error("pending frame lost or overwritten");

endmodule

`default_nettype wire

FILE: rtl/ufcm_match.sv
`default_nettype none

module ufcm_match import ufcm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       frame_valid,
  output logic       frame_ready,
  input  frame_t     frame,
  ufcm_out_if.source out_ch
);

  logic  out_valid_r, out_valid_nxt;
  code_t event_code_r;
  logic  matched_r;
  code_t hit_code;
  logic  hit;
  logic  [8:0] last_pos;
  logic  span_ok;

  assign frame_ready = !out_valid_r || out_ch.ready;

  // compare positions LEN_POS .. LEN_POS+L; a length of 255 lands far past the row
  assign last_pos = {1'b0, frame[LEN_POS]} + 9'(LEN_POS);
  assign span_ok  = last_pos < 9'(CMP_LIMIT);

  always_comb begin
    logic row_ok;
    hit_code = NO_MATCH_CODE;
    hit      = 1'b0;
    // walk rows from the back so the lowest matching row wins
    for (int r = ACTIVE_ROWS - 1; r >= 0; r--) begin
      row_ok = span_ok;
      for (int p = LEN_POS; p < CMP_LIMIT; p++) begin
        if ((9'(p) <= last_pos) && (frame[p] != STATUS_ROWS[r][p])) begin
          row_ok = 1'b0;
        end
      end
      if (row_ok) begin
        hit_code = code_t'(r);
        hit      = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (frame_ready) begin
      out_valid_nxt = frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      event_code_r <= hit_code;
      matched_r    <= hit;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_code = event_code_r;
  assign out_ch.matched    = matched_r;

  a_code_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (matched_r == (event_code_r != NO_MATCH_CODE)))
    else $error("match flag disagrees with event code");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && matched_r |-> event_code_r < code_t'(ACTIVE_ROWS))
    else $error("event code beyond active rows");

endmodule

`default_nettype wire

FILE: tb/uart_frame_command_matcher_core_tb.sv
`timescale 1ns / 1ps

module uart_frame_command_matcher_core_tb import ufcm_pkg::*;;

  // Rough count of bytes that go into frames during the random part.
  localparam int FRAME_BYTE_TARGET = 1800;

  // --------------------------------------------------------------------------
  // Status frame tracker: follows the frame collector byte by byte and queues
  // the event each closed frame should report, then checks the DUT results
  // against that queue in order.
  // --------------------------------------------------------------------------
  class status_match_tracker;
    code_t pending_code [$];
    logic  pending_matched [$];
    int    phase;
    byte_t store [FRAME_BYTES];
    int    errors;

    function new();
      phase  = 0;
      errors = 0;
    endfunction

    // First table row whose bytes 2..2+L equal the frame; L = 255 never matches
    // and any compare position beyond the row or the frame fails that row.
    function code_t find_status_row();
      int  len;
      int  pos;
      bit  hit;
      len = store[LEN_POS];
      if (len == 255) return NO_MATCH_CODE;
      for (int row = 0; row < ACTIVE_ROWS; row++) begin
        hit = 1'b1;
        for (int k = 0; k <= len; k++) begin
          pos = LEN_POS + k;
          if (pos >= ROW_BYTES || pos >= FRAME_BYTES) begin
            hit = 1'b0;
            break;
          end
          if (store[pos] != STATUS_ROWS[row][pos]) begin
            hit = 1'b0;
            break;
          end
        end
        if (hit) return code_t'(row);
      end
      return NO_MATCH_CODE;
    endfunction

    function void note_rx_byte(byte_t b);
      code_t c;
      // idle bytes other than the start byte are dropped
      if (phase == 0 && b != START_BYTE) return;
      store[phase] = b;
      phase++;
      if (phase < FRAME_BYTES) return;
      phase = 0;
      c = find_status_row();
      pending_code.push_back(c);
      pending_matched.push_back(c != NO_MATCH_CODE);
    endfunction

    function void check_event(code_t c, logic m);
      code_t exp_c;
      logic  exp_m;
      if (pending_code.size() == 0) begin
        $display("%0t: unexpected result, event_code=%0d matched=%0b", $time, c, m);
        errors++;
        return;
      end
      exp_c = pending_code.pop_front();
      exp_m = pending_matched.pop_front();
      if (c !== exp_c) begin
        $display("%0t: event_code mismatch, expected %0d actual %0d", $time, exp_c, c);
        errors++;
      end
      if (m !== exp_m) begin
        $display("%0t: matched mismatch, expected %0b actual %0b", $time, exp_m, m);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ufcm_in_if  in_ch ();
  ufcm_out_if out_ch ();

  uart_frame_command_matcher_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  status_match_tracker tracker = new();

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  int calm_left  = 0;   // bytes left in a no-gap stretch
  int frame_bytes = 0;  // bytes sent inside frames (random part)

  // Mostly back-to-back or short gaps, a few long ones, and runs with none.
  function automatic int pick_rx_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One byte transfer; data toggles at random while valid is low.
  task automatic drive_rx_byte(byte_t b);
    int gap;
    gap = pick_rx_gap();
    repeat (gap) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= byte_t'($urandom);
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_rx_byte(b);
  endtask

  task automatic drive_frame(frame_t f);
    for (int i = 0; i < FRAME_BYTES; i++) drive_rx_byte(f[i]);
  endtask

  // Idle noise: anything but the start byte, so it is dropped.
  function automatic byte_t idle_noise();
    byte_t b;
    b = byte_t'($urandom);
    if (b == START_BYTE) b = b ^ 8'h01;
    return b;
  endfunction

  // Random frame: mostly a table row with random don't-care bytes (sometimes
  // with one compared bit flipped), then odd lengths, then pure noise.
  function automatic frame_t make_status_frame();
    frame_t f;
    int     kind;
    int     row;
    int     len;
    int     pos;
    for (int i = 0; i < FRAME_BYTES; i++) f[i] = byte_t'($urandom);
    f[0] = START_BYTE;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      row = $urandom_range(0, TABLE_ROWS - 1);
      len = STATUS_ROWS[row][LEN_POS];
      for (int k = 0; k <= len; k++) f[LEN_POS + k] = STATUS_ROWS[row][LEN_POS + k];
      if ($urandom_range(0, 5) == 0) begin
        pos = $urandom_range(LEN_POS, LEN_POS + len);
        f[pos] = f[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
    end else if (kind < 85) begin
      // row body with an off-table length: 0, 1, 4 (reaches the checksum),
      // past the row, or 255
      row = $urandom_range(0, TABLE_ROWS - 1);
      for (int k = LEN_POS + 1; k < ROW_BYTES; k++) f[k] = STATUS_ROWS[row][k];
      case ($urandom_range(0, 6))
        0:       f[LEN_POS] = 8'h00;
        1:       f[LEN_POS] = 8'h01;
        2:       f[LEN_POS] = 8'h04;
        3:       f[LEN_POS] = 8'h05;
        4:       f[LEN_POS] = 8'hFF;
        5:       f[LEN_POS] = 8'hFE;
        default: f[LEN_POS] = byte_t'($urandom);
      endcase
    end
    // start byte again inside the frame
    if ($urandom_range(0, 7) == 0) f[$urandom_range(1, FRAME_BYTES - 1)] = START_BYTE;
    return f;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls, checks every transfer.
  // --------------------------------------------------------------------------
  int ready_hold = 0;

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        tracker.check_event(out_ch.event_code, out_ch.matched);
      if (ready_hold == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            out_ch.ready <= 1'b1;
            ready_hold = $urandom_range(1, 20);
          end
          6, 7, 8: begin
            out_ch.ready <= 1'b0;
            ready_hold = $urandom_range(1, 3);
          end
          default: begin
            out_ch.ready <= 1'b0;
            ready_hold = $urandom_range(10, 40);
          end
        endcase
      end else begin
        ready_hold--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    byte_t  opening [$];
    frame_t f;
    int     guard;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: dropped idle bytes at both extremes, the short row whose
    // checksum is the start byte, length 255, and the last row with extreme
    // don't-care bytes.
    opening = '{8'h00, 8'hFF, 8'h55,
                8'hAA, 8'h00, 8'h02, 8'h00, 8'h02, 8'hFC, 8'hAA,
                8'hAA, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'hAA, 8'hFF, 8'h03, 8'h0F, 8'h0F, 8'h00, 8'h00};
    foreach (opening[i]) drive_rx_byte(opening[i]);

    // Random frames, some with idle noise in front.
    while (frame_bytes < FRAME_BYTE_TARGET) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) drive_rx_byte(idle_noise());
      f = make_status_frame();
      drive_frame(f);
      frame_bytes += FRAME_BYTES;
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for outstanding events, then wait on for strays.
    guard = 0;
    while (tracker.pending_code.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);

    if (tracker.pending_code.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               tracker.pending_code.size());
      tracker.errors++;
    end

    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #12_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
rtl/ufcm_pkg.sv
rtl/ufcm_in_if.sv
rtl/ufcm_out_if.sv
rtl/ufcm_collect.sv
rtl/ufcm_match.sv
rtl/uart_frame_command_matcher_core.sv
tb/uart_frame_command_matcher_core_tb.sv
